// ===== hdl/ibqm_pkg.sv =====
// Shared types, constants and the micro-program of the inverse bilinear quad map.
package ibqm_pkg;

    localparam int WORD_W = 64;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0001;

    localparam int NUM_FIELDS = 10;
    localparam logic [6:0] PC_LOOP = 7'd38;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [1:0] CFG_ITER_LIMIT = 2'd1;
    localparam logic [1:0] CFG_DET_FLOOR = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [1:0] STATUS_SINGULAR = 2'd1;
    localparam logic [1:0] STATUS_LEFT_RANGE = 2'd2;
    localparam logic [1:0] STATUS_ITER_LIMIT = 2'd3;

    // Register file entries; the first ten match the input field order.
    localparam logic [4:0] R_X0 = 5'd0;
    localparam logic [4:0] R_Y0 = 5'd1;
    localparam logic [4:0] R_X1 = 5'd2;
    localparam logic [4:0] R_Y1 = 5'd3;
    localparam logic [4:0] R_X2 = 5'd4;
    localparam logic [4:0] R_Y2 = 5'd5;
    localparam logic [4:0] R_X3 = 5'd6;
    localparam logic [4:0] R_Y3 = 5'd7;
    localparam logic [4:0] R_PX = 5'd8;
    localparam logic [4:0] R_PY = 5'd9;
    localparam logic [4:0] R_A1 = 5'd10;
    localparam logic [4:0] R_B1 = 5'd11;
    localparam logic [4:0] R_C1 = 5'd12;
    localparam logic [4:0] R_A2 = 5'd13;
    localparam logic [4:0] R_B2 = 5'd14;
    localparam logic [4:0] R_C2 = 5'd15;
    localparam logic [4:0] R_S = 5'd16;
    localparam logic [4:0] R_T = 5'd17;
    localparam logic [4:0] R_RX = 5'd18;
    localparam logic [4:0] R_RY = 5'd19;
    localparam logic [4:0] R_J00 = 5'd20;
    localparam logic [4:0] R_J01 = 5'd21;
    localparam logic [4:0] R_J10 = 5'd22;
    localparam logic [4:0] R_J11 = 5'd23;
    localparam logic [4:0] R_DET = 5'd24;
    localparam logic [4:0] R_T0 = 5'd25;
    localparam logic [4:0] R_T1 = 5'd26;
    localparam logic [4:0] R_T2 = 5'd27;

    typedef enum logic [3:0] {
        OP_LDIN,
        OP_HALF,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_DETCHK,
        OP_RNGCHK,
        OP_CNVCHK
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] dst;
        logic [4:0] a;
        logic [4:0] b;
    } instr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    function automatic instr_t mk(input op_t op, input logic [4:0] d,
                                  input logic [4:0] a, input logic [4:0] b);
        instr_t i;
        i.op = op;
        i.dst = d;
        i.a = a;
        i.b = b;
        return i;
    endfunction

    // One residual r = p - (a*s + b*t + (c*s)*t + d), for x or y.
    function automatic instr_t res_instr(input logic [3:0] k);
        logic [4:0] ra, rb, rc, rd, rp, rr;
        instr_t i;
        ra = k[3] ? R_A2 : R_A1;
        rb = k[3] ? R_B2 : R_B1;
        rc = k[3] ? R_C2 : R_C1;
        rd = k[3] ? R_Y0 : R_X0;
        rp = k[3] ? R_PY : R_PX;
        rr = k[3] ? R_RY : R_RX;
        case (k[2:0])
            3'd0: i = mk(OP_MUL, R_T0, ra, R_S);
            3'd1: i = mk(OP_MUL, R_T1, rb, R_T);
            3'd2: i = mk(OP_ADD, R_T0, R_T0, R_T1);
            3'd3: i = mk(OP_MUL, R_T1, rc, R_S);
            3'd4: i = mk(OP_MUL, R_T1, R_T1, R_T);
            3'd5: i = mk(OP_ADD, R_T0, R_T0, R_T1);
            3'd6: i = mk(OP_ADD, R_T0, R_T0, rd);
            default: i = mk(OP_SUB, rr, rp, R_T0);
        endcase
        return i;
    endfunction

    function automatic instr_t prog_instr(input logic [6:0] pc);
        instr_t i;
        logic [6:0] off;
        i = mk(OP_CNVCHK, R_T0, R_RX, R_RY);
        off = 7'd0;
        if (pc < 7'd10) begin
            i = mk(OP_LDIN, pc[4:0], pc[4:0], pc[4:0]);
        end else if (pc >= 7'd22 && pc <= 7'd37) begin
            off = pc - 7'd22;
            i = res_instr(off[3:0]);
        end else if (pc >= 7'd61 && pc <= 7'd76) begin
            off = pc - 7'd61;
            i = res_instr(off[3:0]);
        end else begin
            case (pc)
                7'd10: i = mk(OP_SUB, R_A1, R_X1, R_X0);
                7'd11: i = mk(OP_SUB, R_B1, R_X3, R_X0);
                7'd12: i = mk(OP_SUB, R_T0, R_X2, R_X1);
                7'd13: i = mk(OP_ADD, R_T0, R_T0, R_X0);
                7'd14: i = mk(OP_SUB, R_C1, R_T0, R_X3);
                7'd15: i = mk(OP_SUB, R_A2, R_Y1, R_Y0);
                7'd16: i = mk(OP_SUB, R_B2, R_Y3, R_Y0);
                7'd17: i = mk(OP_SUB, R_T0, R_Y2, R_Y1);
                7'd18: i = mk(OP_ADD, R_T0, R_T0, R_Y0);
                7'd19: i = mk(OP_SUB, R_C2, R_T0, R_Y3);
                7'd20: i = mk(OP_HALF, R_S, R_S, R_S);
                7'd21: i = mk(OP_HALF, R_T, R_T, R_T);
                7'd38: i = mk(OP_MUL, R_T0, R_C1, R_T);
                7'd39: i = mk(OP_ADD, R_J00, R_A1, R_T0);
                7'd40: i = mk(OP_MUL, R_T0, R_C1, R_S);
                7'd41: i = mk(OP_ADD, R_J01, R_B1, R_T0);
                7'd42: i = mk(OP_MUL, R_T0, R_C2, R_T);
                7'd43: i = mk(OP_ADD, R_J10, R_A2, R_T0);
                7'd44: i = mk(OP_MUL, R_T0, R_C2, R_S);
                7'd45: i = mk(OP_ADD, R_J11, R_B2, R_T0);
                7'd46: i = mk(OP_MUL, R_T0, R_J00, R_J11);
                7'd47: i = mk(OP_MUL, R_T1, R_J01, R_J10);
                7'd48: i = mk(OP_SUB, R_DET, R_T0, R_T1);
                7'd49: i = mk(OP_DETCHK, R_DET, R_DET, R_DET);
                7'd50: i = mk(OP_MUL, R_T0, R_J11, R_RX);
                7'd51: i = mk(OP_MUL, R_T1, R_J01, R_RY);
                7'd52: i = mk(OP_SUB, R_T0, R_T0, R_T1);
                7'd53: i = mk(OP_DIV, R_T0, R_T0, R_DET);
                7'd54: i = mk(OP_MUL, R_T1, R_J00, R_RY);
                7'd55: i = mk(OP_MUL, R_T2, R_J10, R_RX);
                7'd56: i = mk(OP_SUB, R_T1, R_T1, R_T2);
                7'd57: i = mk(OP_DIV, R_T1, R_T1, R_DET);
                7'd58: i = mk(OP_ADD, R_S, R_S, R_T0);
                7'd59: i = mk(OP_ADD, R_T, R_T, R_T1);
                7'd60: i = mk(OP_RNGCHK, R_S, R_S, R_T);
                default: i = mk(OP_CNVCHK, R_T0, R_RX, R_RY);
            endcase
        end
        return i;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic signed [64:0] sum;
        sum = $signed({a[63], a}) + $signed({b[63], b});
        if (sum > $signed({1'b0, SAT_MAX})) return SAT_MAX;
        if (sum < $signed({1'b1, SAT_MIN})) return SAT_MIN;
        return sum[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic logic [63:0] apply_sign(input logic [63:0] m, input logic neg);
        return neg ? (~m + 64'd1) : m;
    endfunction

endpackage

// ===== hdl/inverse_bilinear_quad_map.sv =====
// Inverse bilinear quadrilateral map: Newton solve for (s,t) on shared arithmetic units.
//
// Each input transaction carries the four corners of a quadrilateral and a physical
// point in signed fixed point (FRAC_BITS fractional bits). Starting from (0.5,0.5) the
// block runs Newton steps with the exact inverse of the 2x2 Jacobian until the larger
// residual magnitude is within residual_tolerance, and returns one result transaction
// holding s, t (clamped to [-2,2]), a status and the number of steps taken. All work is
// done by a small micro-program sequencer driving one 64-bit saturating add/subtract,
// one multiplier built from four 32x32 partial products and a restoring divider that
// settles one quotient bit a cycle. Operands live in a 32-entry register file with one
// write and two registered reads. The two divisions by the determinant dominate each
// Newton step. The input side is not ready while an item is being solved; a finished
// result waits in the output register and the next item may be accepted meanwhile.
// Configuration writes are always taken and must only be issued while idle.
module inverse_bilinear_quad_map #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, point_x, point_y, zero padding
    input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // ref_s, ref_t, status, iterations_used, zero padding
    output logic [((2*FRAC_BITS+22)/8)*8-1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import ibqm_pkg::*;

    localparam int OUT_W = FRAC_BITS + 3;
    localparam int M_W = ((2*FRAC_BITS+22)/8)*8;
    localparam int M_PAD = M_W - (2*OUT_W + 9);
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] LIM = 64'd2 << FRAC_BITS;

    // Configuration registers.
    logic [15:0] tol_reg;
    logic [6:0]  ilim_reg;
    logic [15:0] floor_reg;

    // Sequencer and datapath state.
    state_t       state_reg, state_next;
    logic [6:0]   pc_reg, pc_next;
    logic [6:0]   iters_reg, iters_next;
    logic [1:0]   status_reg, status_next;
    logic [10*COORD_WIDTH-1:0] in_reg, in_next;
    logic [63:0]  opa_reg, opb_reg;
    logic [63:0]  s_reg, s_next, t_reg, t_next;
    logic [63:0]  ma_reg, ma_next, mb_reg, mb_next;
    logic         neg_reg, neg_next;
    logic [2:0]   k_reg, k_next;
    logic [127:0] acc_reg, acc_next;
    logic [127:0] num_reg, num_next;
    logic [63:0]  rem_reg, rem_next;
    logic [62:0]  q_reg, q_next;
    logic         ovf_reg, ovf_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] out_s_reg, out_s_next, out_t_reg, out_t_next;
    logic [1:0]   out_status_reg, out_status_next;
    logic [6:0]   out_iters_reg, out_iters_next;

    // Register file.
    logic [63:0] rf [32];
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [63:0] wr_data;

    instr_t instr;
    assign instr = prog_instr(pc_reg);

    // Combinational helpers.
    logic [COORD_WIDTH-1:0] field;
    logic [63:0]  field_sx;
    logic [31:0]  a_half, b_half;
    logic [63:0]  part;
    logic [6:0]   sh;
    logic [127:0] mq;
    logic [63:0]  mul_res;
    logic [63:0]  rr;
    logic         qbit;
    logic [63:0]  rem_after;
    logic [62:0]  q_final;
    logic [6:0]   lim_eff;
    logic [63:0]  mag_a, mag_b;

    assign field = in_reg[instr.a[3:0]*COORD_WIDTH +: COORD_WIDTH];
    assign field_sx = {{(64-COORD_WIDTH){field[COORD_WIDTH-1]}}, field};
    assign a_half = k_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_half = k_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign part = {32'd0, a_half} * {32'd0, b_half};
    assign sh = {k_reg[0] & k_reg[1], k_reg[0] ^ k_reg[1], 5'd0};
    assign mq = acc_reg >> FRAC_BITS;
    assign mul_res = apply_sign((|mq[127:63]) ? SAT_MAX : mq[63:0], neg_reg);
    assign rr = {rem_reg[62:0], num_reg[127]};
    assign qbit = (rr >= mb_reg);
    assign rem_after = qbit ? (rr - mb_reg) : rr;
    assign q_final = {q_reg[61:0], qbit};
    assign lim_eff = (ilim_reg == 7'd0) ? 7'd1 : ilim_reg;
    assign mag_a = mag64(opa_reg);
    assign mag_b = mag64(opb_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {{M_PAD{1'b0}}, out_iters_reg, out_status_reg, out_t_reg, out_s_reg};

    function automatic logic [OUT_W-1:0] clamp_out(input logic [63:0] v);
        logic [63:0] c;
        c = v;
        if ($signed(v) > $signed(LIM)) c = LIM;
        if ($signed(v) < -$signed(LIM)) c = ~LIM + 64'd1;
        return c[OUT_W-1:0];
    endfunction

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg;
        iters_next = iters_reg;
        status_next = status_reg;
        in_next = in_reg;
        s_next = s_reg;
        t_next = t_reg;
        ma_next = ma_reg;
        mb_next = mb_reg;
        neg_next = neg_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_s_next = out_s_reg;
        out_t_next = out_t_reg;
        out_status_next = out_status_reg;
        out_iters_next = out_iters_reg;
        wr_en = 1'b0;
        wr_addr = instr.dst;
        wr_data = 64'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_next = s_tdata[10*COORD_WIDTH-1:0];
                    pc_next = 7'd0;
                    iters_next = 7'd0;
                    status_next = STATUS_ITER_LIMIT;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                pc_next = pc_reg + 7'd1;
                state_next = ST_FETCH;
                case (instr.op)
                    OP_LDIN: begin
                        wr_en = 1'b1;
                        wr_data = field_sx;
                    end
                    OP_HALF: begin
                        wr_en = 1'b1;
                        wr_data = HALF;
                    end
                    OP_ADD: begin
                        wr_en = 1'b1;
                        wr_data = sat_add(opa_reg, opb_reg);
                    end
                    OP_SUB: begin
                        wr_en = 1'b1;
                        wr_data = sat_add(opa_reg, ~opb_reg + 64'd1);
                    end
                    OP_MUL: begin
                        ma_next = mag_a;
                        mb_next = mag_b;
                        neg_next = opa_reg[63] ^ opb_reg[63];
                        acc_next = 128'd0;
                        k_next = 3'd0;
                        pc_next = pc_reg;
                        state_next = ST_MUL;
                    end
                    OP_DIV: begin
                        num_next = {64'd0, mag_a} << FRAC_BITS;
                        mb_next = mag_b;
                        neg_next = opa_reg[63] ^ opb_reg[63];
                        rem_next = 64'd0;
                        q_next = 63'd0;
                        ovf_next = 1'b0;
                        cnt_next = 7'd127;
                        pc_next = pc_reg;
                        state_next = ST_DIV;
                    end
                    OP_DETCHK: begin
                        if (opa_reg == 64'd0 || mag_a < {48'd0, floor_reg}) begin
                            status_next = STATUS_SINGULAR;
                            state_next = ST_FIN;
                        end
                    end
                    OP_RNGCHK: begin
                        iters_next = iters_reg + 7'd1;
                        if ($signed(opa_reg) > $signed(LIM) || $signed(opa_reg) < -$signed(LIM)
                            || $signed(opb_reg) > $signed(LIM)
                            || $signed(opb_reg) < -$signed(LIM)) begin
                            status_next = STATUS_LEFT_RANGE;
                            state_next = ST_FIN;
                        end
                    end
                    OP_CNVCHK: begin
                        if (mag_a <= {48'd0, tol_reg} && mag_b <= {48'd0, tol_reg}) begin
                            status_next = STATUS_CONVERGED;
                            state_next = ST_FIN;
                        end else if (iters_reg >= lim_eff) begin
                            status_next = STATUS_ITER_LIMIT;
                            state_next = ST_FIN;
                        end else begin
                            pc_next = PC_LOOP;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MUL: begin
                if (k_reg[2]) begin
                    wr_en = 1'b1;
                    wr_data = mul_res;
                    pc_next = pc_reg + 7'd1;
                    state_next = ST_FETCH;
                end else begin
                    acc_next = acc_reg + ({64'd0, part} << sh);
                    k_next = k_reg + 3'd1;
                end
            end
            ST_DIV: begin
                num_next = {num_reg[126:0], 1'b0};
                rem_next = rem_after;
                if (cnt_reg >= 7'd63) begin
                    ovf_next = ovf_reg | qbit;
                end else begin
                    q_next = q_final;
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    wr_en = 1'b1;
                    wr_data = apply_sign(ovf_reg ? SAT_MAX : {1'b0, q_final}, neg_reg);
                    pc_next = pc_reg + 7'd1;
                    state_next = ST_FETCH;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_s_next = clamp_out(s_reg);
                    out_t_next = clamp_out(t_reg);
                    out_status_next = status_reg;
                    out_iters_next = iters_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // s and t are shadowed outside the file for the result.
        if (wr_en && wr_addr == R_S) s_next = wr_data;
        if (wr_en && wr_addr == R_T) t_next = wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            tol_reg <= 16'd1;
            ilim_reg <= 7'd16;
            floor_reg <= 16'd1;
        end else begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_TOLERANCE:  tol_reg <= cfg_data;
                    CFG_ITER_LIMIT: ilim_reg <= cfg_data[6:0];
                    CFG_DET_FLOOR:  floor_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pc_reg <= pc_next;
        iters_reg <= iters_next;
        status_reg <= status_next;
        in_reg <= in_next;
        s_reg <= s_next;
        t_reg <= t_next;
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        neg_reg <= neg_next;
        k_reg <= k_next;
        acc_reg <= acc_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        out_s_reg <= out_s_next;
        out_t_reg <= out_t_next;
        out_status_reg <= out_status_next;
        out_iters_reg <= out_iters_next;
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf[wr_addr] <= wr_data;
        end
        if (state_reg == ST_FETCH) begin
            opa_reg <= rf[instr.a];
            opb_reg <= rf[instr.b];
        end
    end

endmodule

// ===== tb/sv/inverse_bilinear_quad_map_checker.sv =====
// Checker for the inverse bilinear quad map: predicts each result and compares it.
`timescale 1ns / 1ps

module inverse_bilinear_quad_map_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [319:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           pending,
    output int           errors
);
    import ibqm_pkg::*;

    localparam int FRAC = 16;
    localparam longint LIM2 = longint'(2) << FRAC;

    typedef struct packed {
        logic [18:0] s;
        logic [18:0] t;
        logic [1:0]  status;
        logic [6:0]  iters;
    } solution_t;

    logic [15:0] tolerance;
    logic [6:0]  step_limit;
    logic [15:0] det_floor;
    solution_t   solutions_due[$];

    function automatic longint sat_sum(input longint a, input longint b);
        logic [64:0] w;
        w = {a[63], a};
        w = w + {b[63], b};
        if (!w[64] && w[63]) return SAT_MAX;
        if (w[64] && (!w[63] || w[63:0] == 64'h8000_0000_0000_0000)) return SAT_MIN;
        return w[63:0];
    endfunction

    function automatic longint sat_diff(input longint a, input longint b);
        return sat_sum(a, -b);
    endfunction

    function automatic logic [63:0] abs64(input longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] p;
        longint m;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        p = p >> FRAC;
        m = (p > {64'd0, SAT_MAX}) ? SAT_MAX : p[63:0];
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint fx_div(input longint n, input longint d);
        logic [127:0] q;
        longint m;
        q = ({64'd0, abs64(n)} << FRAC) / {64'd0, abs64(d)};
        m = (q > {64'd0, SAT_MAX}) ? SAT_MAX : q[63:0];
        return ((n < 0) != (d < 0)) ? -m : m;
    endfunction

    function automatic longint mapped_gap(input longint p, input longint d, input longint a,
                                          input longint b, input longint c,
                                          input longint s, input longint t);
        longint m;
        m = sat_sum(fx_mul(a, s), fx_mul(b, t));
        m = sat_sum(m, fx_mul(fx_mul(c, s), t));
        m = sat_sum(m, d);
        return sat_diff(p, m);
    endfunction

    function automatic longint clamp_two(input longint v);
        if (v > LIM2) return LIM2;
        if (v < -LIM2) return -LIM2;
        return v;
    endfunction

    function automatic solution_t solve_quad(input logic [319:0] d);
        longint f[10];
        longint a1, b1, c1, a2, b2, c2, s, t, rx, ry;
        longint j00, j01, j10, j11, det, ds, dt;
        int limit, steps;
        logic [1:0] st;
        solution_t r;
        for (int i = 0; i < 10; i++) f[i] = longint'($signed(d[32*i +: 32]));
        a1 = sat_diff(f[2], f[0]);
        b1 = sat_diff(f[6], f[0]);
        c1 = sat_diff(sat_sum(sat_diff(f[4], f[2]), f[0]), f[6]);
        a2 = sat_diff(f[3], f[1]);
        b2 = sat_diff(f[7], f[1]);
        c2 = sat_diff(sat_sum(sat_diff(f[5], f[3]), f[1]), f[7]);
        s = longint'(1) << (FRAC - 1);
        t = s;
        rx = mapped_gap(f[8], f[0], a1, b1, c1, s, t);
        ry = mapped_gap(f[9], f[1], a2, b2, c2, s, t);
        limit = (step_limit == 0) ? 1 : step_limit;
        steps = 0;
        st = STATUS_ITER_LIMIT;
        while (steps < limit) begin
            j00 = sat_sum(a1, fx_mul(c1, t));
            j01 = sat_sum(b1, fx_mul(c1, s));
            j10 = sat_sum(a2, fx_mul(c2, t));
            j11 = sat_sum(b2, fx_mul(c2, s));
            det = sat_diff(fx_mul(j00, j11), fx_mul(j01, j10));
            if (det == 0 || abs64(det) < {48'd0, det_floor}) begin
                st = STATUS_SINGULAR;
                break;
            end
            ds = fx_div(sat_diff(fx_mul(j11, rx), fx_mul(j01, ry)), det);
            dt = fx_div(sat_diff(fx_mul(j00, ry), fx_mul(j10, rx)), det);
            s = sat_sum(s, ds);
            t = sat_sum(t, dt);
            steps++;
            rx = mapped_gap(f[8], f[0], a1, b1, c1, s, t);
            ry = mapped_gap(f[9], f[1], a2, b2, c2, s, t);
            if (s > LIM2 || s < -LIM2 || t > LIM2 || t < -LIM2) begin
                st = STATUS_LEFT_RANGE;
                break;
            end
            if (abs64(rx) <= {48'd0, tolerance} && abs64(ry) <= {48'd0, tolerance}) begin
                st = STATUS_CONVERGED;
                break;
            end
        end
        r.s = 19'(clamp_two(s));
        r.t = 19'(clamp_two(t));
        r.status = st;
        r.iters = 7'(steps);
        return r;
    endfunction

    assign pending = solutions_due.size();

    always @(posedge aclk) begin
        solution_t want, got;
        if (!aresetn) begin
            tolerance <= 16'd1;
            step_limit <= 7'd16;
            det_floor <= 16'd1;
            solutions_due.delete();
            errors <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.s = m_tdata[18:0];
                got.t = m_tdata[37:19];
                got.status = m_tdata[39:38];
                got.iters = m_tdata[46:40];
                if (solutions_due.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected result s=%h t=%h status=%0d iters=%0d",
                                 $realtime, got.s, got.t, got.status, got.iters);
                    errors <= errors + 1;
                end else begin
                    want = solutions_due.pop_front();
                    if (got !== want) begin
                        if (errors < 10) begin
                            $write("%0t: mismatch expected s=%h t=%h status=%0d iters=%0d",
                                   $realtime, want.s, want.t, want.status, want.iters);
                            $display(", actual s=%h t=%h status=%0d iters=%0d",
                                     got.s, got.t, got.status, got.iters);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) solutions_due.push_back(solve_quad(s_tdata));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TOLERANCE:  tolerance <= cfg_data;
                    CFG_ITER_LIMIT: step_limit <= cfg_data[6:0];
                    CFG_DET_FLOOR:  det_floor <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/sv/inverse_bilinear_quad_map_tb.sv =====
// Top of the inverse bilinear quad map testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module inverse_bilinear_quad_map_tb;
    import ibqm_pkg::*;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int M_WIDTH = ((2 * FRAC_BITS + 22) / 8) * 8;
    // Longest correct item is 72 steps (a limit written as 200 keeps its low seven bits)
    // plus set-up; allow many times that.
    localparam int QUIET_LIMIT = 200000;
    localparam longint ONE = longint'(1) << FRAC_BITS;
    // An index that names no register; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // corner0_x .. corner3_y, point_x, point_y (32 bits each, lowest first)
    logic [319:0]       s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // ref_s, ref_t, status, iterations_used, zero padding
    logic [M_WIDTH-1:0] m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_TOLERANCE;
    logic [15:0]        cfg_data = '0;

    int  solutions_pending;
    int  mismatch_count;
    int  quiet_cycles = 0;
    int  result_stall = 0;
    bit  steady = 1'b0;

    always #2 aclk = ~aclk;

    inverse_bilinear_quad_map #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    inverse_bilinear_quad_map_checker result_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending(solutions_pending),
        .errors(mismatch_count)
    );

    // The result side stalls at random: mostly short stalls, now and then a long one,
    // and never while the steady stretch is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            result_stall <= 0;
        end else if (result_stall > 0 && !steady) begin
            m_tready <= 1'b0;
            result_stall <= result_stall - 1;
        end else begin
            m_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3: result_stall <= $urandom_range(1, 3);
                4:          result_stall <= $urandom_range(20, 300);
                default:    result_stall <= 0;
            endcase
        end
    end

    // The watchdog counts cycles in which no transaction completes on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [319:0] pack_quad(input longint f[10]);
        logic [319:0] d;
        for (int i = 0; i < 10; i++) d[32*i +: 32] = f[i][31:0];
        return d;
    endfunction

    // A fair quadrilateral of random size with a point mapped from (u,v) near the unit
    // square, so that Newton gets past its first steps; (u,v) sometimes lies well outside.
    function automatic logic [319:0] fair_quad();
        longint f[10];
        longint span, jit, u, v, ax, bx, cx, ay, by, cy;
        span = longint'($urandom_range(1 << 10, 1 << 22));
        jit = span / longint'($urandom_range(2, 16));
        f[0] = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        f[1] = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        f[2] = f[0] + span + longint'($urandom_range(0, 2 * jit)) - jit;
        f[3] = f[1] + longint'($urandom_range(0, 2 * jit)) - jit;
        f[4] = f[0] + span + longint'($urandom_range(0, 2 * jit)) - jit;
        f[5] = f[1] + span + longint'($urandom_range(0, 2 * jit)) - jit;
        f[6] = f[0] + longint'($urandom_range(0, 2 * jit)) - jit;
        f[7] = f[1] + span + longint'($urandom_range(0, 2 * jit)) - jit;
        if ($urandom_range(0, 9) == 0) begin
            u = longint'($urandom_range(0, 5 * ONE)) - 2 * ONE;
            v = longint'($urandom_range(0, 5 * ONE)) - 2 * ONE;
        end else begin
            u = longint'($urandom_range(0, ONE + ONE / 2)) - ONE / 4;
            v = longint'($urandom_range(0, ONE + ONE / 2)) - ONE / 4;
        end
        ax = f[2] - f[0];
        bx = f[6] - f[0];
        cx = f[4] - f[2] + f[0] - f[6];
        ay = f[3] - f[1];
        by = f[7] - f[1];
        cy = f[5] - f[3] + f[1] - f[7];
        f[8] = f[0] + ((ax * u) >>> FRAC_BITS) + ((bx * v) >>> FRAC_BITS)
               + ((((cx * u) >>> FRAC_BITS) * v) >>> FRAC_BITS);
        f[9] = f[1] + ((ay * u) >>> FRAC_BITS) + ((by * v) >>> FRAC_BITS)
               + ((((cy * u) >>> FRAC_BITS) * v) >>> FRAC_BITS);
        return pack_quad(f);
    endfunction

    function automatic logic [319:0] noise_quad();
        logic [319:0] d;
        longint f[10];
        case ($urandom_range(0, 2))
            0: begin
                for (int i = 0; i < 10; i++) d[32*i +: 32] = $urandom();
            end
            1: begin
                // Degenerate: every corner on one spot, so the Jacobian vanishes.
                f[0] = longint'($signed($urandom()));
                f[1] = longint'($signed($urandom()));
                for (int i = 2; i < 8; i++) f[i] = f[i % 2];
                f[8] = longint'($signed($urandom()));
                f[9] = longint'($signed($urandom()));
                d = pack_quad(f);
            end
            default: begin
                // A fair quad whose point is moved far away.
                d = fair_quad();
                d[32*8 +: 32] = $urandom();
                d[32*9 +: 32] = $urandom();
            end
        endcase
        return d;
    endfunction

    // Hands one item over and, unless the next one follows at once, leaves a gap.
    task automatic send_quad(input logic [319:0] d);
        int gap;
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            6:                gap = $urandom_range(30, 400);
            default:          gap = 0;
        endcase
        if (steady) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write of a group.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Stops sending and waits for every outstanding result, then lets the unit settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (solutions_pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic directed_quads();
        longint f[10];
        longint cases[12][10];
        cases[0]  = '{0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE / 2, ONE / 2};
        cases[1]  = '{0, 0, ONE, 0, ONE, ONE, 0, ONE, 0, 0};
        cases[2]  = '{0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE, ONE};
        cases[3]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        cases[4]  = '{0, 0, ONE, 0, ONE, ONE, 0, ONE, 1000 * ONE, -1000 * ONE};
        cases[5]  = '{0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, ONE, ONE};
        cases[6]  = '{0, 0, ONE, ONE, ONE, 0, 0, ONE, ONE / 3, ONE / 4};
        cases[7]  = '{0, 0, 3 * ONE, ONE / 2, 4 * ONE, 5 * ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE};
        cases[8]  = '{-5 * ONE, -5 * ONE, 5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE,
                      -5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE};
        cases[9]  = '{0, 0, 16, 0, 16, 16, 0, 16, 8, 8};
        cases[10] = '{0, 0, ONE, 0, ONE, ONE, 0, ONE, 2 * ONE + ONE / 2, ONE / 2};
        cases[11] = '{0, 0, ONE, 0, 3 * ONE, 3 * ONE, 0, ONE, ONE, ONE};
        foreach (cases[k]) begin
            f = cases[k];
            send_quad(pack_quad(f));
        end
        // Corners all max, all min, alternating (also with a zero point), then all -1.
        send_quad({10{32'h7FFF_FFFF}});
        send_quad({10{32'h8000_0000}});
        send_quad({5{32'h8000_0000, 32'h7FFF_FFFF}});
        send_quad({5{32'h7FFF_FFFF, 32'h8000_0000}});
        send_quad({{2{32'h0}}, {4{32'h7FFF_FFFF, 32'h8000_0000}}});
        send_quad({10{32'hFFFF_FFFF}});
        repeat (4) send_quad(noise_quad());
    endtask

    initial begin
        // Settings per phase: tolerance, step limit (zero and an over-wide value included),
        // determinant floor, and the number of random items.
        int tol_set[7]   = '{1, 0, 65535, 0, 16, 4, 1};
        int limit_set[7] = '{16, 1, 64, 64, 0, 200, 8};
        int floor_set[7] = '{1, 0, 65535, 0, 1000, 0, 300};
        int count_set[7] = '{300, 150, 150, 20, 150, 150, 250};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_quads();

        for (int p = 0; p < 7; p++) begin
            // Every register is rewritten only once the block has gone quiet.
            drain_results();
            write_reg(CFG_TOLERANCE, 16'(tol_set[p]));
            write_reg(CFG_ITER_LIMIT, 16'(limit_set[p]));
            write_reg(CFG_DET_FLOOR, 16'(floor_set[p]));
            if (p == 0) write_reg(CFG_UNUSED, 16'hFFFF);
            cfg_valid <= 1'b0;
            for (int n = 0; n < count_set[p]; n++) begin
                if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                    send_quad(noise_quad());
                else
                    send_quad(fair_quad());
            end
            steady = 1'b0;
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ibqm_pkg.sv
hdl/inverse_bilinear_quad_map.sv
tb/sv/inverse_bilinear_quad_map_checker.sv
tb/sv/inverse_bilinear_quad_map_tb.sv
